// ===== hdl/wlr_pkg.sv =====
// ----------------------------------------------------------------------------
// wlr_pkg
// shared constants and types for the wide line rasterizer
// ----------------------------------------------------------------------------
package wlr_pkg;

	localparam int DEF_COORD_BITS = 16;
	localparam int DEF_MAX_WIDTH  = 16;

	localparam int COLOR_BITS     = 4;
	localparam int WIDTH_BITS     = 5;
	localparam int CFG_DATA_BITS  = 5;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [COLOR_BITS-1:0] WHITE         = 4'd15;
	localparam logic [WIDTH_BITS-1:0] WIDTH_DEFAULT = 5'd1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_COLOR = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH  = 1'b1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef struct packed {
		logic major_is_x;
		logic line_last;
	} col_flags_t;

endpackage

// ===== hdl/wide_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// wide_line_rasterizer
// bresenham line walk that emits a column of pixels across the minor axis
// ----------------------------------------------------------------------------
// usage:
// - input channel (in_valid / in_stall): operation 0 loads the endpoints of a
//   new line, operation 1 advances one step along the major axis
// - a load, or a step with no line loaded, produces no pixels
// - a step produces min(line_width, MAX_WIDTH) pixels on the output channel
//   (out_valid / out_stall), one per cycle while out_stall is low, via the
//   column slot and result register; column_last marks a column's last pixel
// - at width one a request is taken every cycle while out_stall is low; a
//   column of several pixels holds the input until its last pixel is sent,
//   due to the single column slot feeding the result register
// - configuration (cfg_valid / cfg_ready, always ready): index 0 is the
//   pixel color, index 1 the line width; write only while the block is idle
// - reset clears the walk state, sets color to white and width to one
// - when the receiver stalls the result register holds and, once the column
//   slot is full, in_stall rises
// ----------------------------------------------------------------------------
module wide_line_rasterizer #(
	parameter int COORD_BITS = wlr_pkg::DEF_COORD_BITS,
	parameter int MAX_WIDTH  = wlr_pkg::DEF_MAX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wlr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [wlr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic signed [COORD_BITS-1:0]        x_start,
	input  logic signed [COORD_BITS-1:0]        y_start,
	input  logic signed [COORD_BITS-1:0]        x_end,
	input  logic signed [COORD_BITS-1:0]        y_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        pixel_x,
	output logic signed [COORD_BITS-1:0]        pixel_y,
	output logic [wlr_pkg::COLOR_BITS-1:0]      color,
	output logic                                column_last,
	output logic                                line_last
);
	import wlr_pkg::*;

	localparam int CNT_BITS = $clog2(MAX_WIDTH + 1);
	localparam int D_BITS   = COORD_BITS + 1;

	logic [COLOR_BITS-1:0] pixel_color_q;
	logic [WIDTH_BITS-1:0] line_width_q;

	logic                  line_active_q;
	logic                  major_is_x_q;
	logic [COORD_BITS-1:0] major_pos_q;
	logic [COORD_BITS-1:0] major_stop_q;
	logic [COORD_BITS-1:0] minor_pos_q;
	logic [D_BITS-1:0]     major_delta_q;
	logic [D_BITS-1:0]     minor_delta_q;
	logic                  dir_nz_q;
	logic                  dir_neg_q;
	logic [D_BITS-1:0]     error_q;

	logic                  col_ready;
	logic                  col_valid;
	logic                  in_take;
	logic                  do_load;
	logic                  do_step;
	logic [CNT_BITS-1:0]   count;
	logic                  last_col;
	col_flags_t            col_flags;

	logic signed [D_BITS-1:0]     diff_x;
	logic signed [D_BITS-1:0]     diff_y;
	logic [D_BITS-1:0]            abs_x;
	logic [D_BITS-1:0]            abs_y;
	logic                         new_is_x;
	logic signed [COORD_BITS-1:0] maj_a;
	logic signed [COORD_BITS-1:0] maj_b;
	logic signed [COORD_BITS-1:0] min_a;
	logic signed [COORD_BITS-1:0] min_b;
	logic                         swap;
	logic signed [COORD_BITS-1:0] min_lo;
	logic signed [COORD_BITS-1:0] min_hi;

	logic [D_BITS:0]       err_sum;
	logic                  err_wrap;
	logic [COORD_BITS-1:0] minor_step;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_color_q <= WHITE;
			line_width_q  <= WIDTH_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_COLOR: pixel_color_q <= cfg_data[COLOR_BITS-1:0];
				REG_LINE_WIDTH:  line_width_q  <= cfg_data[WIDTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = !col_ready;
	assign in_take  = in_valid && !in_stall;
	assign do_load  = in_take && (operation == OP_LOAD);
	assign do_step  = in_take && (operation == OP_STEP) && line_active_q;

	// load: pick the major axis and order endpoints along it
	assign diff_x   = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
	assign diff_y   = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
	assign abs_x    = diff_x[D_BITS-1] ? D_BITS'(-diff_x) : D_BITS'(diff_x);
	assign abs_y    = diff_y[D_BITS-1] ? D_BITS'(-diff_y) : D_BITS'(diff_y);
	assign new_is_x = abs_y < abs_x;

	assign maj_a  = new_is_x ? x_start : y_start;
	assign maj_b  = new_is_x ? x_end   : y_end;
	assign min_a  = new_is_x ? y_start : x_start;
	assign min_b  = new_is_x ? y_end   : x_end;
	assign swap   = maj_a > maj_b;
	assign min_lo = swap ? min_b : min_a;
	assign min_hi = swap ? min_a : min_b;

	// step: error walk, minor moves once the error reaches the major delta
	assign err_sum    = {1'b0, error_q} + {1'b0, minor_delta_q};
	assign err_wrap   = err_sum >= {1'b0, major_delta_q};
	assign minor_step = !dir_nz_q ? '0 : (dir_neg_q ? '1 : COORD_BITS'(1));
	assign last_col   = (major_pos_q == major_stop_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			major_is_x_q  <= 1'b0;
			major_pos_q   <= '0;
			major_stop_q  <= '0;
			minor_pos_q   <= '0;
			major_delta_q <= '0;
			minor_delta_q <= '0;
			dir_nz_q      <= 1'b0;
			dir_neg_q     <= 1'b0;
			error_q       <= '0;
		end else if (do_load) begin
			line_active_q <= 1'b1;
			major_is_x_q  <= new_is_x;
			major_pos_q   <= swap ? maj_b : maj_a;
			major_stop_q  <= swap ? maj_a : maj_b;
			minor_pos_q   <= min_lo;
			major_delta_q <= new_is_x ? abs_x : abs_y;
			minor_delta_q <= new_is_x ? abs_y : abs_x;
			dir_nz_q      <= (min_hi != min_lo);
			dir_neg_q     <= (min_hi < min_lo);
			error_q       <= '0;
		end else if (do_step) begin
			if (err_wrap) begin
				minor_pos_q <= minor_pos_q + minor_step;
				error_q     <= D_BITS'(err_sum - {1'b0, major_delta_q});
			end else begin
				error_q <= D_BITS'(err_sum);
			end
			if (last_col) begin
				line_active_q <= 1'b0;
			end else begin
				major_pos_q <= major_pos_q + COORD_BITS'(1);
			end
		end
	end

	// pixel count per column, saturated at the emitter depth
	assign count = (32'(line_width_q) > 32'(MAX_WIDTH)) ? CNT_BITS'(MAX_WIDTH)
	                                                     : CNT_BITS'(line_width_q);

	assign col_valid            = do_step && (count != '0);
	assign col_flags.major_is_x = major_is_x_q;
	assign col_flags.line_last  = last_col;

	wlr_column_emitter #(
		.COORD_BITS (COORD_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.col_valid   (col_valid),
		.col_ready   (col_ready),
		.col_major   (major_pos_q),
		.col_minor   (minor_pos_q),
		.col_count   (count),
		.col_color   (pixel_color_q),
		.col_flags   (col_flags),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.color       (color),
		.column_last (column_last),
		.line_last   (line_last)
	);

endmodule

// ===== hdl/wlr_column_emitter.sv =====
// ----------------------------------------------------------------------------
// wlr_column_emitter
// holds one column request and sends its pixels through a result register,
// one per cycle while not stalled; minor offsets run 0,-1,+1,-2,+2,...
// ----------------------------------------------------------------------------
module wlr_column_emitter #(
	parameter int COORD_BITS = wlr_pkg::DEF_COORD_BITS,
	parameter int MAX_WIDTH  = wlr_pkg::DEF_MAX_WIDTH,
	localparam int CNT_BITS  = $clog2(MAX_WIDTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              col_valid,
	output logic                              col_ready,
	input  logic [COORD_BITS-1:0]             col_major,
	input  logic [COORD_BITS-1:0]             col_minor,
	input  logic [CNT_BITS-1:0]               col_count,
	input  logic [wlr_pkg::COLOR_BITS-1:0]    col_color,
	input  wlr_pkg::col_flags_t               col_flags,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [COORD_BITS-1:0]      pixel_x,
	output logic signed [COORD_BITS-1:0]      pixel_y,
	output logic [wlr_pkg::COLOR_BITS-1:0]    color,
	output logic                              column_last,
	output logic                              line_last
);
	import wlr_pkg::*;

	logic                  valid_s1;
	logic [CNT_BITS-1:0]   idx_s1;
	logic [CNT_BITS-1:0]   count_s1;
	logic [COORD_BITS-1:0] major_s1;
	logic [COORD_BITS-1:0] minor_s1;
	logic [COLOR_BITS-1:0] color_s1;
	col_flags_t            flags_s1;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q;
	logic [COORD_BITS-1:0] pixel_y_q;
	logic [COLOR_BITS-1:0] color_q;
	logic                  column_last_q;
	logic                  line_last_q;

	logic                  out_free;
	logic                  emit;
	logic                  last_px;
	logic [CNT_BITS:0]     mag;
	logic [COORD_BITS-1:0] mag_ext;
	logic [COORD_BITS-1:0] offset;
	logic [COORD_BITS-1:0] minor_px;

	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = valid_s1 && out_free;
	assign last_px   = (idx_s1 == count_s1 - CNT_BITS'(1));
	assign col_ready = !valid_s1 || (emit && last_px);

	// offset magnitude is (i+1)/2, negative on odd pixels
	assign mag      = ({1'b0, idx_s1} + (CNT_BITS+1)'(1)) >> 1;
	assign mag_ext  = COORD_BITS'(mag);
	assign offset   = idx_s1[0] ? (~mag_ext + COORD_BITS'(1)) : mag_ext;
	assign minor_px = minor_s1 + offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (col_valid && col_ready) begin
			valid_s1 <= 1'b1;
			idx_s1   <= '0;
		end else if (emit && last_px) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			idx_s1 <= idx_s1 + CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (col_valid && col_ready) begin
			count_s1 <= col_count;
			major_s1 <= col_major;
			minor_s1 <= col_minor;
			color_s1 <= col_color;
			flags_s1 <= col_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q     <= flags_s1.major_is_x ? major_s1 : minor_px;
			pixel_y_q     <= flags_s1.major_is_x ? minor_px : major_s1;
			color_q       <= color_s1;
			column_last_q <= last_px;
			line_last_q   <= flags_s1.line_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = $signed(pixel_x_q);
	assign pixel_y     = $signed(pixel_y_q);
	assign color       = color_q;
	assign column_last = column_last_q;
	assign line_last   = line_last_q;

`ifndef SYNTH
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (count_s1 != '0))
		else $error("held column has zero pixels");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx_s1 < count_s1))
		else $error("pixel index beyond column");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		col_valid |-> col_ready)
		else $error("column offered while previous one still pending");

	a_column_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_px) |=> (out_valid_q && column_last_q && !valid_s1)
			|| (out_valid_q && column_last_q && idx_s1 == '0))
		else $error("column end not marked on its final pixel");
`endif

endmodule
